### rtl/mxp_pkg.sv
// ----------------------------------------------------------------------------
// mxp_pkg: shared types for the maximum XOR pair trie
// Word layouts of the input and result channels.
// ----------------------------------------------------------------------------
package mxp_pkg;

	localparam int VALUE_W = 30;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               start_set;
	} item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] best_xor;
		logic               pool_full;
	} result_t;

endpackage

### rtl/mxp_ram.sv
// ----------------------------------------------------------------------------
// mxp_ram: generic RAM, one write port, two registered read ports
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module mxp_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 30721
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	output logic [WIDTH-1:0]                       rdata_a,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                       rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

### rtl/max_xor_pair_trie.sv
// ----------------------------------------------------------------------------
// max_xor_pair_trie: running maximum XOR of any two values in a set
// Binary trie over a node RAM; query and insert walks share one pass.
// ----------------------------------------------------------------------------
//
//   channel   handshake                   word       direction
//   -------   -------------------------   --------   ---------
//   item      item_valid / item_ready     item_t     into block
//   result    result_valid / result_ready result_t   out of block
//
// A word is walked and, where its path is new, allocated before the next
// word is accepted. The trie walk descends one level per cycle through the
// registered read ports of the node RAM, and the allocation writes one node
// per cycle through its single write port.
// The root node lives in flip-flops, so reset and a start flag empty the set
// at once; the node RAM needs no clearing pass. A finished result waits in
// the output register while the next word is accepted and walked.
// ----------------------------------------------------------------------------
module max_xor_pair_trie
	import mxp_pkg::*;
#(
	parameter int VALUE_BITS = 30,
	parameter int CAPACITY   = 1024
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam int VB         = VALUE_BITS;
	localparam int POOL_NODES = CAPACITY * VALUE_BITS + 1;
	localparam int NODE_LIMIT = POOL_NODES - 1;
	localparam int IDX_W      = $clog2(POOL_NODES);
	localparam int LVL_W      = (VB > 1) ? $clog2(VB) : 1;
	localparam int NEED_W     = $clog2(VB + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WALK  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_LINK  = 3'd3;
	localparam logic [2:0] ST_ALLOC = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	// A trie node: child index for bit 0 and bit 1; zero means no child.
	typedef logic [1:0][IDX_W-1:0] entry_t;

	logic [2:0]       state_q;
	logic [LVL_W-1:0] lvl_q;
	logic [VB-1:0]    val_q;
	entry_t           root_q;
	logic [VB-1:0]    run_max_q;
	logic             set_empty_q;
	logic [IDX_W-1:0] nodes_used_q;
	logic [VB-1:0]    q_res_q;
	logic             q_at_root_q;
	logic             ins_first_q;
	logic [IDX_W-1:0] ins_node_q;
	logic             ins_stop_q;
	logic [LVL_W-1:0] ins_lvl_q;
	entry_t           ins_ent_q;
	logic             full_q;
	result_t          result_q;
	logic             result_valid_q;

	entry_t           rd_a;
	entry_t           rd_b;
	logic             we;
	logic [IDX_W-1:0] waddr;
	entry_t           wdata;

	logic             item_acc;
	logic             cur_bit;
	entry_t           q_ent;
	entry_t           i_ent;
	logic [IDX_W-1:0] q_want;
	logic             q_hit;
	logic [IDX_W-1:0] q_next;
	logic [IDX_W-1:0] i_next;
	logic [NEED_W-1:0] need;
	logic [IDX_W-1:0] room;
	logic             fits;
	logic [VB-1:0]    new_max;
	logic [IDX_W-1:0] fresh;
	logic             link_bit;

	assign item_acc     = item_valid && item_ready;
	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Both walks look at the current node of their own path. On the first
	// level that node is the root, held in flip-flops; afterwards it is the
	// entry read from the RAM in the cycle before.
	assign cur_bit = val_q[lvl_q];
	assign q_ent   = q_at_root_q ? root_q : rd_a;
	assign i_ent   = ins_first_q ? root_q : rd_b;
	assign q_want  = q_ent[~cur_bit];
	assign q_hit   = (q_want != '0);
	assign q_next  = q_hit ? q_want : q_ent[cur_bit];
	assign i_next  = i_ent[cur_bit];

	// Nodes the insert still needs, and whether the pool has that many left.
	assign need = ins_stop_q ? (NEED_W'(ins_lvl_q) + NEED_W'(1)) : '0;
	assign room = IDX_W'(NODE_LIMIT) - nodes_used_q;
	assign fits = (IDX_W'(need) <= room);

	// The query only counts when the set held a value before this one.
	assign new_max = (!set_empty_q && (q_res_q > run_max_q)) ? q_res_q : run_max_q;

	assign fresh    = nodes_used_q + IDX_W'(1);
	assign link_bit = val_q[ins_lvl_q];

	// Write port: the parent link in the link step, one new node per cycle
	// in the allocation steps. A new node points at the node allocated next,
	// which takes the following index, unless it is the leaf.
	always_comb begin
		we    = 1'b0;
		waddr = fresh;
		wdata = '0;
		unique case (state_q)
			ST_LINK: begin
				we              = (ins_node_q != '0);
				waddr           = ins_node_q;
				wdata           = ins_ent_q;
				wdata[link_bit] = fresh;
			end
			ST_ALLOC: begin
				we    = 1'b1;
				waddr = fresh;
				if (lvl_q != '0) begin
					wdata[val_q[lvl_q - LVL_W'(1)]] = fresh + IDX_W'(1);
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	mxp_ram #(
		.WIDTH (2 * IDX_W),
		.DEPTH (POOL_NODES)
	) u_nodes (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (q_next),
		.rdata_a (rd_a),
		.raddr_b (i_next),
		.rdata_b (rd_b)
	);

	// Sequencer and set state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			root_q         <= '0;
			run_max_q      <= '0;
			set_empty_q    <= 1'b1;
			nodes_used_q   <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// In the done step the output register is handled below.
			if (result_valid_q && result_ready && (state_q != ST_DONE)) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						state_q <= ST_WALK;
						if (item.start_set) begin
							root_q       <= '0;
							run_max_q    <= '0;
							set_empty_q  <= 1'b1;
							nodes_used_q <= '0;
						end
					end
				end
				ST_WALK: begin
					if (lvl_q == '0) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					run_max_q <= new_max;
					if (!ins_stop_q) begin
						set_empty_q <= 1'b0;
						state_q     <= ST_DONE;
					end else if (fits) begin
						set_empty_q <= 1'b0;
						state_q     <= ST_LINK;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_LINK: begin
					if (ins_node_q == '0) begin
						root_q[link_bit] <= fresh;
					end
					state_q <= ST_ALLOC;
				end
				ST_ALLOC: begin
					nodes_used_q <= fresh;
					if (lvl_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!result_valid_q || result_ready) begin
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk registers and the result word.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (item_acc) begin
					val_q       <= VB'(item.value);
					lvl_q       <= LVL_W'(VB - 1);
					q_res_q     <= '0;
					q_at_root_q <= 1'b1;
					ins_first_q <= 1'b1;
					ins_node_q  <= '0;
					ins_stop_q  <= 1'b0;
					full_q      <= 1'b0;
				end
			end
			ST_WALK: begin
				if (q_hit) begin
					q_res_q[lvl_q] <= 1'b1;
				end
				q_at_root_q <= (q_next == '0);
				ins_first_q <= 1'b0;
				if (!ins_stop_q) begin
					if (i_next == '0) begin
						ins_stop_q <= 1'b1;
						ins_lvl_q  <= lvl_q;
						ins_ent_q  <= i_ent;
					end else begin
						ins_node_q <= i_next;
					end
				end
				if (lvl_q != '0) begin
					lvl_q <= lvl_q - LVL_W'(1);
				end
			end
			ST_CHECK: begin
				full_q <= ins_stop_q && !fits;
			end
			ST_LINK: begin
				lvl_q <= ins_lvl_q;
			end
			ST_ALLOC: begin
				if (lvl_q != '0) begin
					lvl_q <= lvl_q - LVL_W'(1);
				end
			end
			ST_DONE: begin
				if (!result_valid_q || result_ready) begin
					result_q.best_xor  <= VALUE_W'(run_max_q);
					result_q.pool_full <= full_q;
				end
			end
			default: begin
				lvl_q <= lvl_q;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	// The pool never hands out more nodes than it holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		nodes_used_q <= IDX_W'(NODE_LIMIT))
		else $error("node pool count beyond its limit");

	// Allocation only starts when the pool had room for the whole path.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ALLOC) |-> (nodes_used_q < IDX_W'(NODE_LIMIT)))
		else $error("node allocated from an exhausted pool");

	// An accepted word always starts a trie walk at the top level.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_acc |=> (state_q == ST_WALK) && (lvl_q == LVL_W'(VB - 1)))
		else $error("accepted word did not start a walk");

	// A result is only presented after the walk has passed the check step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result presented outside the done step");
`endif

endmodule

### dv/max_xor_pair_trie_checker.sv
// ----------------------------------------------------------------------------
// max_xor_pair_trie_checker: result predictor and comparator
// Watches both channels of the trie block. Keeps its own binary trie, node
// pool and running maximum. Compares every result word with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module max_xor_pair_trie_checker
	import mxp_pkg::*;
#(
	parameter int VALUE_BITS = 30,
	parameter int CAPACITY   = 1024
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_ready,
	input  item_t   item,
	input  logic    result_valid,
	input  logic    result_ready,
	input  result_t result,
	output int      bad_words,
	output int      due_count
);

	localparam int unsigned POOL = CAPACITY * VALUE_BITS + 1;
	localparam logic [VALUE_W-1:0] VALUE_MASK = VALUE_W'((64'd1 << VALUE_BITS) - 1);

	// Node 0 is the root; a link of 0 means no child.
	int unsigned         link [0:POOL-1][0:1];
	int unsigned         nodes_used;
	logic [VALUE_W-1:0]  running_max;
	bit                  set_empty;
	result_t             max_xor_due[$];
	result_t             due_word;
	int                  words_seen;

	function automatic void clear_trie();
		link[0][0] = 0;
		link[0][1] = 0;
		nodes_used = 0;
		running_max = '0;
		set_empty = 1'b1;
	endfunction

	// Best XOR of v against the values in the trie, taking the opposite
	// branch at every level where it exists.
	function automatic logic [VALUE_W-1:0] probe_best(input logic [VALUE_W-1:0] v);
		int unsigned        node;
		int unsigned        want;
		logic [VALUE_W-1:0] best;
		best = '0;
		node = 0;
		for (int lvl = VALUE_BITS - 1; lvl >= 0; lvl--) begin
			want = link[node][!v[lvl]];
			if (want != 0) begin
				best[lvl] = 1'b1;
				node = want;
			end else begin
				node = link[node][v[lvl]];
			end
			if (node >= POOL)
				node = 0;
		end
		return best;
	endfunction

	// Inserts v; returns 0 and leaves the trie as it is when the pool
	// cannot hold the new part of the path.
	function automatic bit graft(input logic [VALUE_W-1:0] v);
		int unsigned node;
		int unsigned nx;
		int unsigned need;
		int          lvl;
		node = 0;
		lvl = VALUE_BITS - 1;
		while (lvl >= 0) begin
			nx = link[node][v[lvl]];
			if (nx == 0 || nx >= POOL)
				break;
			node = nx;
			lvl--;
		end
		need = lvl + 1;
		if (need > POOL - 1 - nodes_used)
			return 1'b0;
		while (lvl >= 0) begin
			nodes_used++;
			link[nodes_used][0] = 0;
			link[nodes_used][1] = 0;
			link[node][v[lvl]] = nodes_used;
			node = nodes_used;
			lvl--;
		end
		return 1'b1;
	endfunction

	function automatic result_t max_xor_after(input item_t w);
		logic [VALUE_W-1:0] v;
		logic [VALUE_W-1:0] q;
		result_t            r;
		v = w.value & VALUE_MASK;
		if (w.start_set)
			clear_trie();
		if (!set_empty) begin
			q = probe_best(v);
			if (q > running_max)
				running_max = q;
		end
		r.pool_full = !graft(v);
		if (!r.pool_full)
			set_empty = 1'b0;
		r.best_xor = running_max;
		return r;
	endfunction

	function automatic void note_bad();
		bad_words++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_trie();
			max_xor_due.delete();
			bad_words = 0;
			due_count = 0;
			words_seen = 0;
		end else begin
			// The result side goes first: a word leaving now belongs to an
			// item accepted at an earlier edge.
			if (result_valid && result_ready) begin
				if (max_xor_due.size() == 0) begin
					note_bad();
					if (bad_words <= 10)
						$display("%0t: result word %0d with nothing outstanding: best_xor %h pool_full %b",
							$time, words_seen, result.best_xor, result.pool_full);
				end else begin
					due_word = max_xor_due.pop_front();
					if (result.best_xor !== due_word.best_xor ||
					    result.pool_full !== due_word.pool_full) begin
						note_bad();
						if (bad_words <= 10)
							$display("%0t: result word %0d: best_xor exp %h got %h, pool_full exp %b got %b",
								$time, words_seen, due_word.best_xor, result.best_xor,
								due_word.pool_full, result.pool_full);
					end
				end
				words_seen++;
			end
			if (item_valid && item_ready)
				max_xor_due.push_back(max_xor_after(item));
			due_count = max_xor_due.size();
		end
	end

endmodule

### dv/max_xor_pair_trie_tb.sv
// ----------------------------------------------------------------------------
// max_xor_pair_trie_tb: testbench top for the maximum XOR pair trie
// Makes reset, clock and stimulus, and gives the verdict. The checker beside
// the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module max_xor_pair_trie_tb;
	import mxp_pkg::*;

	localparam int VALUE_BITS   = 30;
	localparam int CAPACITY     = 1024;
	localparam int RANDOM_WORDS = 900;
	// The tail and the idle limit each outlast the handling of a single
	// accepted word, and the idle limit also outlasts the long receiver
	// hold-off.
	localparam int TAIL_CYCLES  = 200;
	localparam int LONG_HOLD    = 600;
	localparam int IDLE_LIMIT   = 5000;
	// Enough words in one set to run the node pool dry (see the fill phase).
	localparam int FILL_WORDS   = 1440;
	localparam logic [VALUE_W-1:0] ALL_ONES = '1;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	int      bad_words;
	int      due_count;
	bit      hold_off_req;
	int      burst_left;
	int      idle_cycles;
	// Values of the set being built, used to shape related values.
	logic [VALUE_W-1:0] recent[$];

	max_xor_pair_trie #(
		.VALUE_BITS (VALUE_BITS),
		.CAPACITY   (CAPACITY)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	max_xor_pair_trie_checker #(
		.VALUE_BITS (VALUE_BITS),
		.CAPACITY   (CAPACITY)
	) u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.bad_words    (bad_words),
		.due_count    (due_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Bit-reversed counter. Consecutive values split the trie as high up as
	// possible, so every insert allocates close to a full path of nodes.
	function automatic logic [VALUE_W-1:0] mirror30(input int unsigned k);
		logic [VALUE_W-1:0] r;
		for (int b = 0; b < VALUE_W; b++)
			r[VALUE_W-1-b] = k[b];
		return r;
	endfunction

	// Random value, half the time tied to a value already in the set: a long
	// shared prefix, the complement, a copy or a single flipped bit. These
	// drive the walk deep into the trie, unlike plain random values, which
	// split near the root.
	function automatic logic [VALUE_W-1:0] shaped_value();
		logic [VALUE_W-1:0] base;
		if (recent.size() == 0)
			base = VALUE_W'($urandom);
		else
			base = recent[$urandom_range(0, recent.size() - 1)];
		case ($urandom_range(0, 9))
			0, 1, 2: return VALUE_W'($urandom);
			3, 4:    return base ^ VALUE_W'($urandom_range(0, 1023));
			5:       return ~base;
			6:       return base;
			7:       return base ^ (VALUE_W'(1) << $urandom_range(0, VALUE_W - 1));
			8: begin
				if ($urandom_range(0, 1) == 0)
					return '0;
				return ALL_ONES;
			end
			default: begin
				if ($urandom_range(0, 1) == 0)
					return {10'h3FF, 20'($urandom)};
				return {10'h000, 20'($urandom)};
			end
		endcase
	endfunction

	// The sender runs in bursts. At the end of a burst valid drops for a
	// random gap, mostly short, now and then longer than a whole trie walk,
	// so gaps land on every phase of the block's work. Some bursts are long
	// stretches with no gap at all.
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			item_valid <= 1'b0;
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(0, 90)) @(negedge clk);
			else
				repeat ($urandom_range(0, 8)) @(negedge clk);
			if ($urandom_range(0, 4) == 0)
				burst_left = $urandom_range(40, 120);
			else
				burst_left = $urandom_range(0, 10);
		end
	endtask

	// Presents one word at the falling edge and holds it until the block
	// takes it at a rising edge.
	task automatic offer(input logic [VALUE_W-1:0] v, input bit first);
		@(negedge clk);
		item_valid <= 1'b1;
		item.value <= v;
		item.start_set <= first;
		do
			@(posedge clk);
		while (!item_ready);
		pace();
	endtask

	// Stops offering until every outstanding result word has come back.
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		wait (due_count == 0);
	endtask

	// Receiver. It picks a mode for a random number of cycles: always ready,
	// ready half the time, ready rarely, a full stall, or toggling. Once the
	// top asks, it holds ready low for a long stretch on its own count while
	// the sender keeps offering, which fills the block and stalls its input.
	initial begin
		int mode;
		int mode_left;
		bit held;
		result_ready = 1'b0;
		mode = 0;
		mode_left = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req && !held) begin
				held = 1'b1;
				result_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 4);
					mode_left = $urandom_range(1, 60);
				end
				mode_left--;
				case (mode)
					0:       result_ready <= 1'b1;
					1:       result_ready <= ($urandom_range(0, 1) == 0);
					2:       result_ready <= ($urandom_range(0, 4) == 0);
					3:       result_ready <= 1'b0;
					default: result_ready <= mode_left[0];
				endcase
			end
		end
	end

	// Watchdog: the run ends when nothing has moved on either channel for
	// too long.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("max_xor_pair_trie_tb NOT OK");
		$finish;
	end

	initial begin
		int          sent;
		int          set_len;
		bit          first;
		logic [VALUE_W-1:0] v;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		hold_off_req = 1'b0;
		burst_left = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words. The very first one carries no start flag, so the
		// set is empty only by reset. Then the extremes of the value field,
		// copies, a start that wipes a nonzero maximum, back-to-back starts
		// and alternating bit patterns.
		offer(30'd5, 1'b0);
		offer(30'h2AAAAAAA, 1'b0);
		offer(ALL_ONES, 1'b0);
		offer(30'd0, 1'b1);
		offer(ALL_ONES, 1'b0);
		offer(30'd0, 1'b0);
		offer(ALL_ONES, 1'b1);
		offer(ALL_ONES, 1'b0);
		offer(30'h20000000, 1'b0);
		offer(30'h00000001, 1'b0);
		offer(30'd1, 1'b1);
		offer(30'd1, 1'b1);
		offer(30'h15555555, 1'b1);
		offer(30'h2AAAAAAA, 1'b0);
		offer(30'h3FFF0000, 1'b1);
		offer(30'h0000FFFF, 1'b0);
		offer(30'h3FFFFFFE, 1'b0);
		offer(30'h00000000, 1'b0);
		drain();

		// Pool fill. Bit-reversed counter values allocate close to a full
		// path each, so the pool runs out a little past the first thousand
		// and four hundred words and later inserts are refused. Values one
		// node away from an existing path then use up the last few nodes,
		// and a copy of an existing value still fits into a full pool.
		offer(mirror30(0), 1'b1);
		for (int k = 1; k < FILL_WORDS; k++)
			offer(mirror30(k), 1'b0);
		for (int k = 0; k < 20; k++)
			offer(mirror30(k) ^ VALUE_W'(1), 1'b0);
		offer(mirror30(7), 1'b0);
		offer(mirror30(2000), 1'b0);
		drain();

		// Random sets. Most open with a start flag and hold related values;
		// a few lack the start and a few carry a stray one mid-set. Set sizes
		// are mostly small, sometimes a single word, now and then large.
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			case ($urandom_range(0, 9))
				0:       set_len = 1;
				1:       set_len = $urandom_range(100, 200);
				default: set_len = $urandom_range(2, 40);
			endcase
			recent.delete();
			for (int i = 0; i < set_len && sent < RANDOM_WORDS; i++) begin
				if (i == 0)
					first = ($urandom_range(0, 15) != 0);
				else
					first = ($urandom_range(0, 99) == 0);
				v = shaped_value();
				offer(v, first);
				sent++;
				if (first)
					recent.delete();
				recent.push_back(v);
				if (recent.size() > 64)
					void'(recent.pop_front());
				// The hold-off starts away from a drain point, so the sender
				// keeps offering while the receiver is held.
				if (sent == 320)
					hold_off_req = 1'b1;
				if (sent % 150 == 0)
					drain();
			end
		end
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (bad_words == 0 && due_count == 0)
			$display("max_xor_pair_trie_tb OK");
		else
			$display("max_xor_pair_trie_tb NOT OK");
		$finish;
	end

endmodule
